// ===== rtl/sschb_pkg.sv =====
// Shared types, codes and constants of the serial speed command decoder.
package sschb_pkg;

    localparam int LINE_BUFFER_SIZE_DEF = 10;
    localparam int QUEUE_DEPTH          = 2;

    localparam int MAG_W = 13;
    localparam int REG_W = 12;
    localparam int IDX_W = 2;

    localparam logic [MAG_W-1:0] MAG_MAX = {MAG_W{1'b1}};

    // Register indexes of the configuration port.
    localparam logic [IDX_W-1:0] CFG_SPEED_LIMIT  = 2'd0;
    localparam logic [IDX_W-1:0] CFG_SLOW_BOUND   = 2'd1;
    localparam logic [IDX_W-1:0] CFG_NORMAL_BOUND = 2'd2;

    localparam logic [REG_W-1:0] SPEED_LIMIT_RST  = 12'd2000;
    localparam logic [REG_W-1:0] SLOW_BOUND_RST   = 12'd1333;
    localparam logic [REG_W-1:0] NORMAL_BOUND_RST = 12'd1666;

    // Character codes.
    localparam logic [7:0] CH_NUL   = 8'd0;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_VT    = 8'd11;
    localparam logic [7:0] CH_FF    = 8'd12;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_PLUS  = 8'd43;
    localparam logic [7:0] CH_MINUS = 8'd45;
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_NINE  = 8'd57;

    // Direction codes.
    localparam logic [1:0] DIR_STOP = 2'd0;
    localparam logic [1:0] DIR_FWD  = 2'd1;
    localparam logic [1:0] DIR_REV  = 2'd2;

    // Speed classes.
    localparam logic [1:0] CLASS_SLOW   = 2'd0;
    localparam logic [1:0] CLASS_NORMAL = 2'd1;
    localparam logic [1:0] CLASS_FAST   = 2'd2;

    typedef struct packed {
        logic             negative;
        logic [MAG_W-1:0] magnitude;
    } t_line;

    typedef struct packed {
        logic [REG_W-1:0] speed_limit;
        logic [REG_W-1:0] slow_bound;
        logic [REG_W-1:0] normal_bound;
    } t_cfg;

    typedef struct packed {
        logic signed [12:0] speed;
        logic [11:0]        pulse_width;
        logic               forward_pin;
        logic               reverse_pin;
        logic               reversal_pause;
        logic [1:0]         speed_class;
    } t_result;

endpackage

// ===== rtl/sschb_stream_if.sv =====
// Valid/ready stream channel carrying one payload item per handshake.
interface sschb_stream_if #(
    parameter type T = logic [7:0]
);
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/serial_speed_command_hbridge_drive.sv =====
// Top level of the serial speed command decoder for an H-bridge drive.
//
//  Channel   Direction  Payload                                   Handshake
//  i_rx_if   in         rx_byte, 8 bit                            valid/ready
//  o_res_if  out        speed, pulse_width, pins, pause, class    valid/ready
//  i_cfg_*   in         speed_limit, slow_bound, normal_bound     write enable
//
// One item is taken every clock cycle while the queue has room. A line end is written
// into the line queue when it is accepted and moves on in turn into the result register
// once that register is free; the parser, the two-entry line queue and the result register
// each hold their own work, so the input stalls only when the queue is full, that is when
// results go untaken. Reset is synchronous and active low; it restores the register
// defaults and empties the line in hand. No clearing pass follows reset.
module serial_speed_command_hbridge_drive #(
    parameter int LINE_BUFFER_SIZE = sschb_pkg::LINE_BUFFER_SIZE_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    sschb_stream_if.sink                i_rx_if,
    sschb_stream_if.source              o_res_if,
    input  logic                        i_cfg_we,
    input  logic [sschb_pkg::IDX_W-1:0] i_cfg_index,
    input  logic [sschb_pkg::REG_W-1:0] i_cfg_data
);
    import sschb_pkg::*;

    t_cfg  r_cfg;
    logic  w_push;
    logic  w_pop;
    logic  w_full;
    logic  w_empty;
    t_line w_line_in;
    t_line w_line_out;

    // Configuration registers. A write to an index beyond the list is dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.speed_limit  <= SPEED_LIMIT_RST;
            r_cfg.slow_bound   <= SLOW_BOUND_RST;
            r_cfg.normal_bound <= NORMAL_BOUND_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SPEED_LIMIT:  r_cfg.speed_limit  <= i_cfg_data;
                CFG_SLOW_BOUND:   r_cfg.slow_bound   <= i_cfg_data;
                CFG_NORMAL_BOUND: r_cfg.normal_bound <= i_cfg_data;
                default:          r_cfg              <= r_cfg;
            endcase
        end
    end

    // The parser sees every byte and hands over a line only at its end.
    sschb_front #(
        .LINE_BUFFER_SIZE (LINE_BUFFER_SIZE)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rx_if      (i_rx_if),
        .i_queue_full (w_full),
        .o_push       (w_push),
        .o_line       (w_line_in)
    );

    sschb_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_line_in),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_data  (w_line_out)
    );

    // The drive stage keeps the previous direction and the result register.
    sschb_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_empty  (w_empty),
        .i_line   (w_line_out),
        .o_pop    (w_pop),
        .o_res_if (o_res_if)
    );

`ifndef SYNTH
    // A stopped drive has both pins low and zero pulse width, and only then.
    a_stop_pins: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_if.valid |-> ((o_res_if.payload.pulse_width == 12'd0) ==
                            (!o_res_if.payload.forward_pin && !o_res_if.payload.reverse_pin)))
        else $error("pulse width and bridge pins disagree");

    // A reversal pause only comes with a new direction applied.
    a_pause_dir: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_if.valid && o_res_if.payload.reversal_pause) |->
            (o_res_if.payload.forward_pin || o_res_if.payload.reverse_pin))
        else $error("reversal pause without a direction");

    // The sign of the speed matches the reverse pin.
    a_speed_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_if.valid |-> (o_res_if.payload.speed[12] == o_res_if.payload.reverse_pin))
        else $error("speed sign and reverse pin disagree");

    // A queued line is never dropped: a push into a full queue cannot occur.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_full |-> !w_push)
        else $error("line queue overflow");
`endif

endmodule

// ===== rtl/sschb_front.sv =====
// Line parser: accepts bytes, accumulates the number and queues finished lines.
module sschb_front #(
    parameter int LINE_BUFFER_SIZE = sschb_pkg::LINE_BUFFER_SIZE_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    sschb_stream_if.sink        i_rx_if,
    input  logic                i_queue_full,
    output logic                o_push,
    output sschb_pkg::t_line    o_line
);
    import sschb_pkg::*;

    localparam int CW = $clog2(LINE_BUFFER_SIZE);
    localparam logic [CW-1:0] KEEP_MAX = CW'(LINE_BUFFER_SIZE - 1);

    typedef enum logic [1:0] {
        PH_SKIP,
        PH_DIGITS,
        PH_DONE
    } t_phase;

    t_phase           r_phase, n_phase;
    logic [CW-1:0]    r_count, n_count;
    logic             r_neg, n_neg;
    logic [MAG_W-1:0] r_mag, n_mag;

    logic [7:0]       w_c;
    logic             w_accept;
    logic             w_term;
    logic             w_digit;
    logic             w_space;
    logic [16:0]      w_acc;

    assign i_rx_if.ready = !i_queue_full;
    assign w_c      = i_rx_if.payload;
    assign w_accept = i_rx_if.valid && i_rx_if.ready;
    assign w_term   = (w_c == CH_CR) || (w_c == CH_LF);
    assign w_digit  = (w_c >= CH_ZERO) && (w_c <= CH_NINE);
    assign w_space  = (w_c == CH_TAB) || (w_c == CH_VT) || (w_c == CH_FF) ||
                      (w_c == CH_SPACE);
    // Times ten as two shifts, then the new digit.
    assign w_acc    = ({4'b0, r_mag} << 3) + ({4'b0, r_mag} << 1) + {13'b0, w_c[3:0]};

    assign o_push = w_accept && w_term;
    assign o_line = '{negative: r_neg, magnitude: r_mag};

    always_comb begin
        n_phase = r_phase;
        n_count = r_count;
        n_neg   = r_neg;
        n_mag   = r_mag;
        if (w_accept && w_term) begin
            n_phase = PH_SKIP;
            n_count = '0;
            n_neg   = 1'b0;
            n_mag   = '0;
        end else if (w_accept && (r_count < KEEP_MAX)) begin
            n_count = r_count + 1'b1;
            unique case (r_phase)
                PH_SKIP: begin
                    if (!w_space) begin
                        priority if (w_c == CH_PLUS) begin
                            n_phase = PH_DIGITS;
                        end else if (w_c == CH_MINUS) begin
                            n_neg   = 1'b1;
                            n_phase = PH_DIGITS;
                        end else if (w_digit) begin
                            n_mag   = {9'b0, w_c[3:0]};
                            n_phase = PH_DIGITS;
                        end else begin
                            // Any other byte, the zero byte included, ends parsing.
                            n_phase = PH_DONE;
                        end
                    end
                end
                PH_DIGITS: begin
                    if (w_digit) begin
                        n_mag = (w_acc[16:13] != 4'b0) ? MAG_MAX : w_acc[MAG_W-1:0];
                    end else begin
                        n_phase = PH_DONE;
                    end
                end
                default: begin
                    n_phase = PH_DONE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SKIP;
            r_count <= '0;
            r_neg   <= 1'b0;
            r_mag   <= '0;
        end else begin
            r_phase <= n_phase;
            r_count <= n_count;
            r_neg   <= n_neg;
            r_mag   <= n_mag;
        end
    end

endmodule

// ===== rtl/sschb_fifo.sv =====
// Short queue of finished lines between the parser and the drive stage.
module sschb_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  sschb_pkg::t_line i_data,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_empty,
    output sschb_pkg::t_line o_data
);
    import sschb_pkg::*;

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int NW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(QUEUE_DEPTH - 1);

    t_line         r_mem [QUEUE_DEPTH];
    logic [AW-1:0] r_wr, r_rd;
    logic [NW-1:0] r_num;

    assign o_full  = (r_num == NW'(QUEUE_DEPTH));
    assign o_empty = (r_num == '0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_num <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == LAST) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == LAST) ? '0 : r_rd + 1'b1;
            end
            unique case ({i_push, i_pop})
                2'b10:   r_num <= r_num + 1'b1;
                2'b01:   r_num <= r_num - 1'b1;
                default: r_num <= r_num;
            endcase
        end
    end

endmodule

// ===== rtl/sschb_back.sv =====
// Drive stage: clamps a queued line, works out direction, pause and class.
module sschb_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  sschb_pkg::t_cfg  i_cfg,
    input  logic             i_empty,
    input  sschb_pkg::t_line i_line,
    output logic             o_pop,
    sschb_stream_if.source   o_res_if
);
    import sschb_pkg::*;

    logic             r_valid;
    t_result          r_res;
    logic [1:0]       r_prev_dir;

    logic [REG_W-1:0] w_mag;
    logic [1:0]       w_dir;
    logic             w_pause;
    logic [1:0]       w_class;
    logic [12:0]      w_spd;

    assign o_pop = !i_empty && (!r_valid || o_res_if.ready);

    always_comb begin
        w_mag = (i_line.magnitude > {1'b0, i_cfg.speed_limit}) ?
                i_cfg.speed_limit : i_line.magnitude[REG_W-1:0];
        priority if (w_mag == '0) begin
            w_dir = DIR_STOP;
        end else if (i_line.negative) begin
            w_dir = DIR_REV;
        end else begin
            w_dir = DIR_FWD;
        end
        w_pause = ((w_dir == DIR_FWD) && (r_prev_dir == DIR_REV)) ||
                  ((w_dir == DIR_REV) && (r_prev_dir == DIR_FWD));
        // The slow test is made first, so it wins if the bounds are out of order.
        priority if (w_mag <= i_cfg.slow_bound) begin
            w_class = CLASS_SLOW;
        end else if (w_mag <= i_cfg.normal_bound) begin
            w_class = CLASS_NORMAL;
        end else begin
            w_class = CLASS_FAST;
        end
        w_spd = (w_dir == DIR_REV) ? (13'd0 - {1'b0, w_mag}) : {1'b0, w_mag};
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_res.speed          <= $signed(w_spd);
            r_res.pulse_width    <= w_mag;
            r_res.forward_pin    <= (w_dir == DIR_FWD);
            r_res.reverse_pin    <= (w_dir == DIR_REV);
            r_res.reversal_pause <= w_pause;
            r_res.speed_class    <= w_class;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= 1'b0;
            r_prev_dir <= DIR_STOP;
        end else begin
            if (o_pop) begin
                r_valid    <= 1'b1;
                r_prev_dir <= w_dir;
            end else if (o_res_if.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_res_if.valid   = r_valid;
    assign o_res_if.payload = r_res;

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the serial speed command decoder of the H-bridge drive.
`timescale 1ns / 100ps

module tb;

    import sschb_pkg::*;

    // Bytes of a line beyond this count are dropped by the decoder.
    localparam int LINE_KEEP = LINE_BUFFER_SIZE_DEF - 1;

    // Index that lies beyond the register list; a write to it must change nothing.
    localparam logic [IDX_W-1:0] CFG_UNUSED = 2'd3;

    localparam int PHASE_ITEMS    = 205;
    localparam int MAX_GAP        = 40;
    localparam int HOLD_CYCLES    = 300;
    localparam int SETTLE_CYCLES  = 4;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef enum logic [1:0] {
        PH_BLANKS,
        PH_DIGITS,
        PH_DONE
    } t_parse_phase;

    // Tracks the decoder's line state and settings, and holds the drive commands that
    // accepted line ends are expected to produce, oldest first.
    class speed_command_tracker;
        logic [REG_W-1:0] limit_reg;
        logic [REG_W-1:0] slow_reg;
        logic [REG_W-1:0] normal_reg;
        logic [3:0]       kept_chars;
        t_parse_phase     phase;
        logic             minus_seen;
        logic [MAG_W-1:0] mag_acc;
        logic [1:0]       last_dir;
        t_result          pending_commands[$];
        int               errors;

        function new();
            limit_reg  = SPEED_LIMIT_RST;
            slow_reg   = SLOW_BOUND_RST;
            normal_reg = NORMAL_BOUND_RST;
            kept_chars = '0;
            phase      = PH_BLANKS;
            minus_seen = 1'b0;
            mag_acc    = '0;
            last_dir   = DIR_STOP;
            errors     = 0;
        endfunction

        function void write_setting(logic [IDX_W-1:0] idx, logic [REG_W-1:0] val);
            case (idx)
                CFG_SPEED_LIMIT:  limit_reg  = val;
                CFG_SLOW_BOUND:   slow_reg   = val;
                CFG_NORMAL_BOUND: normal_reg = val;
                default: ;
            endcase
        endfunction

        // Decimal conversion rules: blanks, an optional sign, then digits.
        function void parse_char(logic [7:0] c);
            int  acc;
            bit  is_digit;
            is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
            if (phase == PH_BLANKS) begin
                if (c == CH_TAB || c == CH_VT || c == CH_FF || c == CH_SPACE) begin
                end else if (c == CH_PLUS) begin
                    phase = PH_DIGITS;
                end else if (c == CH_MINUS) begin
                    minus_seen = 1'b1;
                    phase      = PH_DIGITS;
                end else if (is_digit) begin
                    mag_acc = MAG_W'(c - CH_ZERO);
                    phase   = PH_DIGITS;
                end else begin
                    phase = PH_DONE;
                end
            end else if (phase == PH_DIGITS) begin
                if (is_digit) begin
                    acc     = int'(mag_acc) * 10 + int'(c - CH_ZERO);
                    mag_acc = (acc > int'(MAG_MAX)) ? MAG_MAX : MAG_W'(acc);
                end else begin
                    phase = PH_DONE;
                end
            end
        endfunction

        function void note_rx_byte(logic [7:0] c);
            logic [MAG_W-1:0] clamped;
            logic [REG_W-1:0] pw;
            logic [1:0]       dir;
            t_result          cmd;
            if (c != CH_CR && c != CH_LF) begin
                if (kept_chars < LINE_KEEP) begin
                    kept_chars++;
                    parse_char(c);
                end
            end else begin
                clamped = (mag_acc > limit_reg) ? MAG_W'(limit_reg) : mag_acc;
                pw      = clamped[REG_W-1:0];
                if (pw == 0)
                    dir = DIR_STOP;
                else if (minus_seen)
                    dir = DIR_REV;
                else
                    dir = DIR_FWD;
                cmd.speed          = (dir == DIR_REV) ? -$signed({1'b0, pw})
                                                      : $signed({1'b0, pw});
                cmd.pulse_width    = pw;
                cmd.forward_pin    = (dir == DIR_FWD);
                cmd.reverse_pin    = (dir == DIR_REV);
                cmd.reversal_pause = (dir == DIR_FWD && last_dir == DIR_REV) ||
                                     (dir == DIR_REV && last_dir == DIR_FWD);
                if (pw <= slow_reg)
                    cmd.speed_class = CLASS_SLOW;
                else if (pw <= normal_reg)
                    cmd.speed_class = CLASS_NORMAL;
                else
                    cmd.speed_class = CLASS_FAST;
                pending_commands.push_back(cmd);
                last_dir   = dir;
                kept_chars = '0;
                phase      = PH_BLANKS;
                minus_seen = 1'b0;
                mag_acc    = '0;
            end
        endfunction

        function void compare_field(string name, logic signed [31:0] want,
                                    logic signed [31:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_command(t_result got);
            t_result want;
            if (pending_commands.size() == 0) begin
                $display("%0t: result with nothing expected, expected none, actual speed %0d",
                         $time, $signed(got.speed));
                errors++;
            end else begin
                want = pending_commands.pop_front();
                compare_field("speed", $signed(want.speed), $signed(got.speed));
                compare_field("pulse_width", want.pulse_width, got.pulse_width);
                compare_field("forward_pin", want.forward_pin, got.forward_pin);
                compare_field("reverse_pin", want.reverse_pin, got.reverse_pin);
                compare_field("reversal_pause", want.reversal_pause, got.reversal_pause);
                compare_field("speed_class", want.speed_class, got.speed_class);
            end
        endfunction
    endclass

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             cfg_we;
    logic [IDX_W-1:0] cfg_index;
    logic [REG_W-1:0] cfg_data;

    sschb_stream_if #(.T(logic [7:0])) rx_if ();
    sschb_stream_if #(.T(t_result))    res_if ();

    speed_command_tracker tracker = new();

    // Knobs shared between the stimulus, the receiver and the helpers. The percentages
    // are the chance, per cycle, of the sender idling or the receiver stalling.
    int send_idle_pct = 0;
    int stall_pct     = 0;
    bit hold_request  = 1'b0;
    int cur_limit     = SPEED_LIMIT_RST;
    int sent_items    = 0;

    serial_speed_command_hbridge_drive dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rx_if     (rx_if),
        .o_res_if    (res_if),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // The receiver. It stalls at random at the rate of the current phase, and on request
    // it holds off for a long stretch so that the line queue fills and the input stalls.
    initial begin
        int hold_left;
        hold_left = 0;
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_if.ready <= 1'b0;
            end else if (stall_pct > 0) begin
                res_if.ready <= ($urandom_range(99) >= stall_pct);
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    // Handshakes are sampled at the rising edge, before any of this edge's updates land.
    // An accepted input byte is run through the predictor; an accepted result is checked
    // against the oldest command still expected.
    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n === 1'b1) begin
                if (rx_if.valid && rx_if.ready)
                    tracker.note_rx_byte(rx_if.payload);
                if (res_if.valid && res_if.ready)
                    tracker.check_command(res_if.payload);
            end
        end
    end

    // Watchdog: too long without any handshake on either channel ends the run as failed.
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((rx_if.valid && rx_if.ready) || (res_if.valid && res_if.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("status: fail");
        $finish;
    end

    // Offers one byte and returns at the edge that accepts it. Any idle gap is taken
    // first, so a valid that stays high is never lowered and raised in the same step.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = 0;
        while (send_idle_pct > 0 && gap < MAX_GAP && $urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0) begin
            rx_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        rx_if.valid   <= 1'b1;
        rx_if.payload <= b;
        do begin
            @(posedge i_clk);
        end while (!rx_if.ready);
        sent_items++;
    endtask

    function automatic logic [7:0] pick_blank();
        case ($urandom_range(3))
            0:       return CH_TAB;
            1:       return CH_VT;
            2:       return CH_FF;
            default: return CH_SPACE;
        endcase
    endfunction

    // One command line. Most are well formed with random content, aimed at values near
    // the present speed limit as well as small and oversized ones; the rest are broken
    // lines built from parser-relevant characters, or plain noise over the whole byte range.
    task automatic send_random_line();
        logic [7:0] text[$];
        logic [7:0] digits[$];
        int         kind;
        int         n;
        int         v;
        int         pick;
        kind = $urandom_range(99);
        if (kind < 70) begin
            n = $urandom_range(2);
            repeat (n) text.push_back(pick_blank());
            case ($urandom_range(3))
                0:       ;
                1:       text.push_back(CH_PLUS);
                default: text.push_back(CH_MINUS);
            endcase
            pick = $urandom_range(9);
            if (pick < 3)
                v = $urandom_range(20);
            else if (pick < 6)
                v = cur_limit + int'($urandom_range(6)) - 3;
            else if (pick < 8)
                v = $urandom_range(4095);
            else
                v = $urandom_range(99999);
            if (v < 0)
                v = 0;
            if ($urandom_range(7) == 0)
                text.push_back(CH_ZERO);
            do begin
                digits.push_front(CH_ZERO + 8'(v % 10));
                v = v / 10;
            end while (v > 0);
            text = {text, digits};
            // Now and then trailing junk, whose digits must not count.
            if ($urandom_range(9) == 0) begin
                text.push_back(8'($urandom_range(8'h3A, 8'h7E)));
                text.push_back(CH_ZERO + 8'($urandom_range(9)));
            end
        end else if (kind < 85) begin
            n = $urandom_range(12);
            repeat (n) begin
                case ($urandom_range(4))
                    0:       text.push_back(pick_blank());
                    1:       text.push_back($urandom_range(1) ? CH_PLUS : CH_MINUS);
                    2:       text.push_back(CH_ZERO + 8'($urandom_range(9)));
                    3:       text.push_back(CH_NUL);
                    default: text.push_back(8'($urandom_range(8'h0E, 8'hFF)));
                endcase
            end
        end else begin
            n = $urandom_range(1, 12);
            repeat (n) text.push_back(8'($urandom_range(255)));
        end
        text.push_back($urandom_range(1) ? CH_CR : CH_LF);
        foreach (text[k])
            send_byte(text[k]);
    endtask

    // Drops valid, waits for every expected command, then lets the pipeline go quiet.
    task automatic settle();
        rx_if.valid <= 1'b0;
        while (tracker.pending_commands.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // One register write; the caller lowers the write enable after the last one.
    task automatic cfg_cycle(input logic [IDX_W-1:0] idx, input logic [REG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        tracker.write_setting(idx, val);
        @(posedge i_clk);
    endtask

    // Writes the unused index if asked, then the three registers while the decoder is idle,
    // and runs a block of random lines under the given idling and stalling and an optional long receiver hold-off.
    task automatic run_phase(input logic [REG_W-1:0] limit, input logic [REG_W-1:0] slow,
                             input logic [REG_W-1:0] normal, input int idle_pct,
                             input int stall_pct_v, input bit hold_off, input bit stray_write);
        int first;
        if (stray_write)
            cfg_cycle(CFG_UNUSED, REG_W'($urandom_range(4095)));
        cfg_cycle(CFG_SPEED_LIMIT, limit);
        cfg_cycle(CFG_SLOW_BOUND, slow);
        cfg_cycle(CFG_NORMAL_BOUND, normal);
        cfg_we        <= 1'b0;
        cur_limit     = limit;
        send_idle_pct = idle_pct;
        stall_pct     = stall_pct_v;
        hold_request  = hold_off;
        first         = sent_items;
        while (sent_items - first < PHASE_ITEMS)
            send_random_line();
        settle();
    endtask

    // Directed lines under the reset settings: an empty line; blanks of every kind, a minus
    // sign and an overlong run of nines that saturates and clamps; a plus sign with a zero
    // byte cutting the number short, which also reverses direction; a sign with no digits;
    // and a line starting with the top byte value, which is not a number.
    logic [7:0] directed_bytes[] = '{
        CH_CR,
        CH_TAB, CH_VT, CH_FF, CH_SPACE, CH_MINUS,
        CH_NINE, CH_NINE, CH_NINE, CH_NINE, CH_NINE, CH_LF,
        CH_PLUS, CH_ZERO + 8'd7, CH_NUL, CH_ZERO + 8'd5, CH_CR,
        CH_MINUS, CH_CR,
        8'hFF, CH_ZERO + 8'd3, CH_LF
    };

    initial begin
        i_rst_n       <= 1'b0;
        rx_if.valid   <= 1'b0;
        rx_if.payload <= CH_NUL;
        cfg_we        <= 1'b0;
        cfg_index     <= CFG_SPEED_LIMIT;
        cfg_data      <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings are checked by leaving them untouched here.
        foreach (directed_bytes[k])
            send_byte(directed_bytes[k]);
        settle();

        // Settings run from the widest limit to a limit of one and a limit of zero, with
        // bounds at both ends and in the wrong order, so the slow test must win.
        run_phase(SPEED_LIMIT_RST, SLOW_BOUND_RST, NORMAL_BOUND_RST, 0, 0, 1'b0, 1'b0);
        run_phase(12'd4095, 12'd0, 12'd4095, 46, 0, 1'b0, 1'b1);
        run_phase(12'd1, 12'd0, 12'd0, 0, 46, 1'b0, 1'b0);
        run_phase(12'd0, 12'd4095, 12'd0, 35, 35, 1'b0, 1'b0);
        run_phase(12'd3000, 12'd2500, 12'd1000, 0, 0, 1'b1, 1'b0);
        run_phase(REG_W'($urandom_range(4095)), REG_W'($urandom_range(4095)),
                  REG_W'($urandom_range(4095)), 35, 35, 1'b0, 1'b0);

        if (tracker.errors == 0 && tracker.pending_commands.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
